/* sv/dpq_pkg.sv */
`default_nettype none

package dpq_pkg;

    localparam logic [2:0] MODE_INSERT     = 3'd0;
    localparam logic [2:0] MODE_REMOVE_MAX = 3'd1;
    localparam logic [2:0] MODE_REMOVE_MIN = 3'd2;
    localparam logic [2:0] MODE_REPORT     = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_START,
        DP_CLEAR,
        DP_FREE_RD,
        DP_ALLOC,
        DP_PUSH_INIT,
        DP_UP_RD,
        DP_UP_STEP,
        DP_UP_PLACE,
        DP_TOP_RD,
        DP_FLAG_RD,
        DP_POP_FREE,
        DP_POP_MARK,
        DP_DN_RD,
        DP_DN_STEP,
        DP_DN_PLACE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel;      // 1 max heap, 0 min heap
        logic   capture;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic any_empty;
        logic full;
        logic up_root;
        logic up_above;
        logic dn_leaf;
        logic dn_more;
        logic stale;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_ALLOC,
        S_PUSH,
        S_UP,
        S_UP_STEP,
        S_TOP,
        S_FLAG,
        S_CHK,
        S_DN,
        S_DN_STEP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        STG_FIRST,
        STG_MAX,
        STG_MIN
    } t_stage;

endpackage

`default_nettype wire

/* sv/double_ended_priority_queue_core.sv */
// channel  direction  handshake            payload
// input    in         i_valid / o_stall    i_mode, i_value
// output   out        o_valid / i_stall    o_result_value, o_min_value, o_status
//
// one word worked on at a time; an insert reads the free list, allocates a slot and
// climbs the key up the max heap, then the min heap; a removal or report reads each
// heap top and its removed flag, and on each pop sifts the last entry down the heap.
// reset is synchronous; slots are handed out from a fresh-slot counter, so no
// clearing pass. a stalled result waits in the output register while the next word
// is accepted and worked on.

`default_nettype none

module double_ended_priority_queue_core
    import dpq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_mode,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed      [31:0] o_result_value,
    output logic signed      [31:0] o_min_value,
    output logic             [1:0]  o_status
);

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic               load, out_free;
    logic [1:0]         status;
    logic signed [31:0] res, mn;
    logic               r_o_valid;
    logic signed [31:0] r_res, r_min;
    logic [1:0]         r_status;

    assign out_free = !r_o_valid || !i_stall;

    dpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_mode     (i_mode),
        .o_stall    (o_stall),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .i_out_free (out_free),
        .o_load     (load),
        .o_status   (status)
    );

    dpq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_value),
        .o_stat  (stat),
        .o_res   (res),
        .o_min   (mn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res    <= res;
            r_min    <= mn;
            r_status <= status;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_result_value = r_res;
    assign o_min_value    = r_min;
    assign o_status       = r_status;

endmodule

`default_nettype wire

/* sv/dpq_heap_ram.sv */
`default_nettype none

module dpq_heap_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 42
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic      [DW-1:0] o_rdata0,
    output logic      [DW-1:0] o_rdata1
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire

/* sv/dpq_datapath.sv */
`default_nettype none

module dpq_datapath
    import dpq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic signed [31:0] i_value,
    output t_dp_stat                o_stat,
    output logic signed      [31:0] o_res,
    output logic signed      [31:0] o_min
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 32 + AW;

    // heap entry: {slot, value}
    logic [CW-1:0] r_max_size, r_min_size, r_live, r_fresh, r_free_cnt, r_n;
    logic [AW-1:0] r_pos, r_free_rd;
    logic [EW-1:0] r_key;
    logic [31:0]   r_value, r_res, r_min;
    logic          r_flag;

    logic          r_removed [CAPACITY];
    logic [AW-1:0] r_free_mem [CAPACITY];

    logic [EW-1:0] max_rd0, max_rd1, min_rd0, min_rd1, rd0, rd1;
    logic [CW-1:0] size_sel;
    logic [AW-1:0] parent, best_idx, alloc_slot, rd0_slot;
    logic [AW+1:0] c1, c2, n_ext;
    logic          c2_ok, pick2, up_above, dn_more, dn_leaf, full;
    logic [EW-1:0] best;
    logic          we, re;
    logic [AW-1:0] waddr, raddr0, raddr1;
    logic [EW-1:0] wdata;

    function automatic logic ranks(input logic is_max, input logic [31:0] a,
                                   input logic [31:0] b);
        ranks = is_max ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    always_comb begin
        rd0      = i_cmd.sel ? max_rd0 : min_rd0;
        rd1      = i_cmd.sel ? max_rd1 : min_rd1;
        rd0_slot = rd0[EW-1:32];
        size_sel = i_cmd.sel ? r_max_size : r_min_size;
        parent   = AW'((r_pos - 1'b1) >> 1);
        c1       = (AW+2)'({r_pos, 1'b1});
        c2       = c1 + 1'b1;
        n_ext    = (AW+2)'(r_n);
        dn_leaf  = c1 >= n_ext;
        c2_ok    = c2 < n_ext;
        pick2    = c2_ok && ranks(i_cmd.sel, rd1[31:0], rd0[31:0]);
        best     = pick2 ? rd1 : rd0;
        best_idx = pick2 ? c2[AW-1:0] : c1[AW-1:0];
        dn_more  = ranks(i_cmd.sel, best[31:0], r_key[31:0]);
        up_above = ranks(i_cmd.sel, r_key[31:0], rd0[31:0]);
        full     = (r_free_cnt == '0) && (r_fresh == CW'(CAPACITY));
        alloc_slot = (r_free_cnt != '0) ? r_free_rd : r_fresh[AW-1:0];

        re     = 1'b0;
        raddr0 = '0;
        raddr1 = '0;
        we     = 1'b0;
        waddr  = r_pos;
        wdata  = r_key;
        case (i_cmd.op)
            DP_UP_RD: begin
                re     = 1'b1;
                raddr0 = parent;
            end
            DP_TOP_RD: begin
                re     = 1'b1;
                raddr1 = AW'(size_sel - 1'b1);
            end
            DP_DN_RD: begin
                re     = 1'b1;
                raddr0 = c1[AW-1:0];
                raddr1 = c2[AW-1:0];
            end
            DP_UP_STEP: begin
                we    = 1'b1;
                wdata = up_above ? rd0 : r_key;
            end
            DP_DN_STEP: begin
                we    = 1'b1;
                wdata = dn_more ? best : r_key;
            end
            DP_UP_PLACE, DP_DN_PLACE: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
            end
        endcase

        o_stat.empty     = size_sel == '0;
        o_stat.any_empty = (r_max_size == '0) || (r_min_size == '0);
        o_stat.full      = full;
        o_stat.up_root   = r_pos == '0;
        o_stat.up_above  = up_above;
        o_stat.dn_leaf   = dn_leaf;
        o_stat.dn_more   = dn_more;
        o_stat.stale     = r_flag;
    end

    dpq_heap_ram #(.DEPTH(CAPACITY), .AW(AW), .DW(EW)) u_max_heap (
        .i_clk    (i_clk),
        .i_we     (we && i_cmd.sel),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_re     (re && i_cmd.sel),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (max_rd0),
        .o_rdata1 (max_rd1)
    );

    dpq_heap_ram #(.DEPTH(CAPACITY), .AW(AW), .DW(EW)) u_min_heap (
        .i_clk    (i_clk),
        .i_we     (we && !i_cmd.sel),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_re     (re && !i_cmd.sel),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (min_rd0),
        .o_rdata1 (min_rd1)
    );

    // removed flags, written on insert and on removal
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_ALLOC) begin
            r_removed[alloc_slot] <= 1'b0;
        end else if (i_cmd.op == DP_POP_MARK) begin
            r_removed[rd0_slot] <= 1'b1;
        end
        if (i_cmd.op == DP_FLAG_RD) begin
            r_flag <= r_removed[rd0_slot];
        end
    end

    // recycled slots; never-used slots come from r_fresh
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_POP_FREE) begin
            r_free_mem[r_free_cnt[AW-1:0]] <= rd0_slot;
        end
        if (i_cmd.op == DP_FREE_RD) begin
            r_free_rd <= r_free_mem[AW'(r_free_cnt - 1'b1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= '0;
            r_min_size <= '0;
            r_live     <= '0;
            r_fresh    <= '0;
            r_free_cnt <= '0;
        end else begin
            case (i_cmd.op)
                DP_CLEAR: begin
                    r_max_size <= '0;
                    r_min_size <= '0;
                    r_live     <= '0;
                    r_fresh    <= '0;
                    r_free_cnt <= '0;
                end
                DP_ALLOC: begin
                    r_live <= r_live + 1'b1;
                    if (r_free_cnt != '0) begin
                        r_free_cnt <= r_free_cnt - 1'b1;
                    end else begin
                        r_fresh <= r_fresh + 1'b1;
                    end
                end
                DP_PUSH_INIT: begin
                    if (i_cmd.sel) begin
                        r_max_size <= r_max_size + 1'b1;
                    end else begin
                        r_min_size <= r_min_size + 1'b1;
                    end
                end
                DP_POP_FREE, DP_POP_MARK: begin
                    if (i_cmd.sel) begin
                        r_max_size <= r_max_size - 1'b1;
                    end else begin
                        r_min_size <= r_min_size - 1'b1;
                    end
                    if (i_cmd.op == DP_POP_MARK) begin
                        r_live <= r_live - 1'b1;
                    end else begin
                        r_free_cnt <= r_free_cnt + 1'b1;
                    end
                end
                default: begin
                    r_live <= r_live;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_START, DP_CLEAR: begin
                r_res   <= '0;
                r_min   <= '0;
                r_value <= i_value;
            end
            DP_ALLOC: begin
                r_key <= {alloc_slot, r_value};
            end
            DP_PUSH_INIT: begin
                r_pos <= size_sel[AW-1:0];
            end
            DP_UP_STEP: begin
                if (up_above) begin
                    r_pos <= parent;
                end
            end
            DP_POP_FREE, DP_POP_MARK: begin
                r_key <= rd1;
                r_pos <= '0;
                r_n   <= size_sel - 1'b1;
                if (i_cmd.op == DP_POP_MARK) begin
                    r_res <= rd0[31:0];
                end
            end
            DP_DN_STEP: begin
                if (dn_more) begin
                    r_pos <= best_idx;
                end
            end
            default: begin
                if (i_cmd.capture) begin
                    if (i_cmd.sel) begin
                        r_res <= rd0[31:0];
                    end else begin
                        r_min <= rd0[31:0];
                    end
                end
            end
        endcase
    end

    assign o_res = r_res;
    assign o_min = r_min;

`ifndef ASSERT_OFF
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_CLEAR |=> r_max_size == '0 && r_min_size == '0 && r_live == '0)
        else $error("clear left entries behind");
    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_ALLOC |-> !full)
        else $error("slot allocated from a full store");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_POP_FREE || i_cmd.op == DP_POP_MARK) |-> size_sel != '0)
        else $error("pop from an empty heap");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= r_fresh)
        else $error("free list holds more slots than were handed out");
`endif

endmodule

`default_nettype wire

/* sv/dpq_ctrl.sv */
`default_nettype none

module dpq_ctrl
    import dpq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [2:0] i_mode,
    output logic            o_stall,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd,
    input  wire logic       i_out_free,
    output logic            o_load,
    output logic [1:0]      o_status
);

    t_state     r_state, n_state;
    t_stage     r_stage, n_stage;
    logic [2:0] r_mode, n_mode;
    logic [1:0] r_status, n_status;
    logic       r_sel, n_sel;
    logic       r_marking, n_marking;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stage   <= STG_FIRST;
            r_mode    <= MODE_INSERT;
            r_status  <= STATUS_OK;
            r_sel     <= 1'b1;
            r_marking <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stage   <= n_stage;
            r_mode    <= n_mode;
            r_status  <= n_status;
            r_sel     <= n_sel;
            r_marking <= n_marking;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_stage       = r_stage;
        n_mode        = r_mode;
        n_status      = r_status;
        n_sel         = r_sel;
        n_marking     = r_marking;
        o_cmd.op      = DP_NOP;
        o_cmd.sel     = r_sel;
        o_cmd.capture = 1'b0;
        o_load        = 1'b0;
        o_stall       = r_state != S_IDLE;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode    = i_mode;
                    n_status  = STATUS_OK;
                    n_marking = 1'b0;
                    o_cmd.op  = DP_START;
                    case (i_mode)
                        MODE_INSERT: begin
                            if (i_stat.full) begin
                                n_status = STATUS_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FREE;
                            end
                        end
                        MODE_REMOVE_MAX, MODE_REMOVE_MIN: begin
                            n_sel   = i_mode == MODE_REMOVE_MAX;
                            n_stage = STG_FIRST;
                            n_state = S_TOP;
                        end
                        MODE_REPORT: begin
                            n_sel   = 1'b1;
                            n_stage = STG_MAX;
                            n_state = S_TOP;
                        end
                        MODE_CLEAR: begin
                            o_cmd.op = DP_CLEAR;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FREE: begin
                o_cmd.op = DP_FREE_RD;
                n_state  = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.op = DP_ALLOC;
                n_sel    = 1'b1;
                n_state  = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.op = DP_PUSH_INIT;
                n_state  = S_UP;
            end
            S_UP, S_UP_STEP: begin
                if (r_state == S_UP && !i_stat.up_root) begin
                    o_cmd.op = DP_UP_RD;
                    n_state  = S_UP_STEP;
                end else if (r_state == S_UP_STEP && i_stat.up_above) begin
                    o_cmd.op = DP_UP_STEP;
                    n_state  = S_UP;
                end else begin
                    // key settles here; then the other heap or done
                    o_cmd.op = (r_state == S_UP) ? DP_UP_PLACE : DP_UP_STEP;
                    if (r_sel) begin
                        n_sel   = 1'b0;
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TOP, S_CHK: begin
                if (r_state == S_TOP && !i_stat.empty) begin
                    o_cmd.op = DP_TOP_RD;
                    n_state  = S_FLAG;
                end else if (r_state == S_CHK && i_stat.stale) begin
                    o_cmd.op  = DP_POP_FREE;
                    n_marking = 1'b0;
                    n_state   = S_DN;
                end else if (r_state == S_CHK && r_stage == STG_FIRST) begin
                    o_cmd.op  = DP_POP_MARK;
                    n_marking = 1'b1;
                    n_state   = S_DN;
                end else begin
                    // live top or empty heap: this stage is finished
                    o_cmd.capture = (r_state == S_CHK) && (r_mode == MODE_REPORT);
                    case (r_stage)
                        STG_FIRST: begin
                            n_status = STATUS_EMPTY;
                            n_state  = S_DONE;
                        end
                        STG_MAX: begin
                            n_stage = STG_MIN;
                            n_sel   = 1'b0;
                            n_state = S_TOP;
                        end
                        default: begin
                            if (r_mode == MODE_REPORT && i_stat.any_empty) begin
                                n_status = STATUS_EMPTY;
                            end
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FLAG: begin
                o_cmd.op = DP_FLAG_RD;
                n_state  = S_CHK;
            end
            S_DN, S_DN_STEP: begin
                if (r_state == S_DN && !i_stat.dn_leaf) begin
                    o_cmd.op = DP_DN_RD;
                    n_state  = S_DN_STEP;
                end else if (r_state == S_DN_STEP && i_stat.dn_more) begin
                    o_cmd.op = DP_DN_STEP;
                    n_state  = S_DN;
                end else begin
                    o_cmd.op = (r_state == S_DN) ? DP_DN_PLACE : DP_DN_STEP;
                    n_state  = S_TOP;
                    if (r_marking) begin
                        // after a removal, sweep stale tops from both heaps
                        n_marking = 1'b0;
                        n_stage   = STG_MAX;
                        n_sel     = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status = r_status;

endmodule

`default_nettype wire
